// ===== rtl/gscw_pkg.sv =====
`timescale 1ns / 1ps
package gscw_pkg;

   localparam int COORD_W   = 23;
   localparam int CELL_W    = 5;
   localparam int IDX_W     = 10;
   localparam int DIVS_W    = 6;
   localparam int GRID_DIVS = 32;
   localparam int MAX_CELLS = 63;
   localparam int FRAC_W    = 16;
   localparam int NUM_W     = COORD_W + FRAC_W;
   localparam int T_W       = 48;
   localparam int CNT_W     = 6;

   localparam logic AXIS_X = 1'b0;
   localparam logic AXIS_Y = 1'b1;

   localparam logic [1:0] REG_CWX  = 2'd0;
   localparam logic [1:0] REG_CWY  = 2'd1;
   localparam logic [1:0] REG_DIVS = 2'd2;

   // Setup divisions, done once per axis in this order.
   typedef enum logic [2:0] {
      OP_QSTART = 3'd0,
      OP_QEND   = 3'd1,
      OP_CSTART = 3'd2,
      OP_CEND   = 3'd3,
      OP_TMAX   = 3'd4,
      OP_TDEL   = 3'd5
   } op_type;

   typedef struct packed {
      logic   load;
      logic   div_start;
      logic   store;
      logic   walk_init;
      logic   emit;
      op_type op;
      logic   axis;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic walk_last;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/gscw_div.sv =====
`timescale 1ns / 1ps
module gscw_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [gscw_pkg::NUM_W-1:0]   num,
   input  logic [gscw_pkg::COORD_W-1:0] den,
   output logic                         done,
   output logic [gscw_pkg::NUM_W-1:0]   quot,
   output logic [gscw_pkg::COORD_W-1:0] rem
);
   import gscw_pkg::*;

   logic [NUM_W-1:0]   quo_ff, quo_in;
   logic [COORD_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               done_ff, done_in;
   logic [COORD_W:0]   trial, diff;
   logic               ge;

   // Restoring division, one quotient bit per cycle, MSB first.
   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      ge      = trial >= {1'b0, den};
      diff    = trial - {1'b0, den};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = num;
         rem_in = '0;
         cnt_in = CNT_W'(NUM_W);
      end else if (cnt_ff != '0) begin
         quo_in  = {quo_ff[NUM_W-2:0], ge};
         rem_in  = ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff;

endmodule

// ===== rtl/gscw_dp.sv =====
`timescale 1ns / 1ps
module gscw_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  gscw_pkg::cmd_type            cmd,
   output gscw_pkg::status_type         status,
   input  logic [gscw_pkg::COORD_W-1:0] start_x,
   input  logic [gscw_pkg::COORD_W-1:0] start_y,
   input  logic [gscw_pkg::COORD_W-1:0] end_x,
   input  logic [gscw_pkg::COORD_W-1:0] end_y,
   input  logic [gscw_pkg::COORD_W-1:0] width_x,
   input  logic [gscw_pkg::COORD_W-1:0] width_y,
   input  logic [gscw_pkg::DIVS_W-1:0]  divs,
   input  logic                         out_ready,
   output logic                         out_valid,
   output logic [gscw_pkg::IDX_W-1:0]   cell_index,
   output logic [gscw_pkg::CELL_W-1:0]  cell_col,
   output logic [gscw_pkg::CELL_W-1:0]  cell_row,
   output logic                         last_cell,
   output logic                         overrun
);
   import gscw_pkg::*;

   logic [COORD_W-1:0] x1_ff, y1_ff, x2_ff, y2_ff;
   logic [COORD_W-1:0] q1_ff [2];
   logic [COORD_W-1:0] q2_ff [2];
   logic [COORD_W-1:0] r_ff [2];
   logic [CELL_W-1:0]  cell_ff [2];
   logic [CELL_W-1:0]  endc_ff [2];
   logic [NUM_W-1:0]   tmax_ff [2];
   logic [NUM_W-1:0]   tdel_ff [2];

   logic [CELL_W-1:0]  cx_ff, cy_ff, cx_in, cy_in;
   logic [T_W-1:0]     tx_ff, ty_ff, tx_in, ty_in;
   logic [CNT_W-1:0]   n_ff, n_in;

   logic               vld_ff, vld_in;
   logic [IDX_W-1:0]   idx_ff;
   logic [CELL_W-1:0]  col_ff, row_ff;
   logic               last_ff, over_ff;

   logic [COORD_W-1:0] a1, a2, w, mag_sel, edge_gap;
   logic               up_sel;
   logic               up_x, up_y, inf_x, inf_y;
   logic [COORD_W-1:0] mag_x, mag_y;
   logic [NUM_W-1:0]   div_num, div_quot;
   logic [COORD_W-1:0] div_den, div_rem;
   logic               div_done;

   logic               stx, sty, out_x, out_y, at_end, last;
   logic [CELL_W-1:0]  nx, ny;
   logic [CELL_W+DIVS_W-1:0] prod, idx_sum;

   assign up_x  = x2_ff > x1_ff;
   assign up_y  = y2_ff > y1_ff;
   assign inf_x = x2_ff == x1_ff;
   assign inf_y = y2_ff == y1_ff;
   assign mag_x = up_x ? x2_ff - x1_ff : x1_ff - x2_ff;
   assign mag_y = up_y ? y2_ff - y1_ff : y1_ff - y2_ff;

   always_comb begin
      a1      = (cmd.axis == AXIS_Y) ? y1_ff : x1_ff;
      a2      = (cmd.axis == AXIS_Y) ? y2_ff : x2_ff;
      w       = (cmd.axis == AXIS_Y) ? width_y : width_x;
      mag_sel = (cmd.axis == AXIS_Y) ? mag_y : mag_x;
      up_sel  = (cmd.axis == AXIS_Y) ? up_y : up_x;
      // A downward step measures from the cell's lower edge.
      edge_gap = up_sel ? w - r_ff[cmd.axis] : r_ff[cmd.axis];
      unique case (cmd.op)
         OP_QSTART: begin
            div_num = NUM_W'(a1);
            div_den = w;
         end
         OP_QEND: begin
            div_num = NUM_W'(a2);
            div_den = w;
         end
         OP_CSTART: begin
            div_num = NUM_W'(q1_ff[cmd.axis]);
            div_den = COORD_W'(divs);
         end
         OP_CEND: begin
            div_num = NUM_W'(q2_ff[cmd.axis]);
            div_den = COORD_W'(divs);
         end
         OP_TMAX: begin
            div_num = {edge_gap, FRAC_W'(0)};
            div_den = mag_sel;
         end
         OP_TDEL: begin
            div_num = {w, FRAC_W'(0)};
            div_den = mag_sel;
         end
         default: begin
            div_num = '0;
            div_den = w;
         end
      endcase
   end

   gscw_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x1_ff <= start_x;
         y1_ff <= start_y;
         x2_ff <= end_x;
         y2_ff <= end_y;
      end
      if (cmd.store) begin
         unique case (cmd.op)
            OP_QSTART: begin
               q1_ff[cmd.axis] <= div_quot[COORD_W-1:0];
               r_ff[cmd.axis]  <= div_rem;
            end
            OP_QEND:   q2_ff[cmd.axis]   <= div_quot[COORD_W-1:0];
            OP_CSTART: cell_ff[cmd.axis] <= div_rem[CELL_W-1:0];
            OP_CEND:   endc_ff[cmd.axis] <= div_rem[CELL_W-1:0];
            OP_TMAX:   tmax_ff[cmd.axis] <= div_quot;
            OP_TDEL:   tdel_ff[cmd.axis] <= div_quot;
            default: ;
         endcase
      end
   end

   // One DDA step per emitted cell; a tie steps both axes.
   always_comb begin
      stx    = !inf_x && (inf_y || tx_ff <= ty_ff);
      sty    = !inf_y && (inf_x || ty_ff <= tx_ff);
      nx     = up_x ? cx_ff + 1'b1 : cx_ff - 1'b1;
      ny     = up_y ? cy_ff + 1'b1 : cy_ff - 1'b1;
      out_x  = stx && (up_x ? (DIVS_W'(cx_ff) + 1'b1 >= divs) : (cx_ff == '0));
      out_y  = sty && (up_y ? (DIVS_W'(cy_ff) + 1'b1 >= divs) : (cy_ff == '0));
      at_end = (cx_ff == endc_ff[AXIS_X]) && (cy_ff == endc_ff[AXIS_Y]);
      last   = at_end || (n_ff == CNT_W'(MAX_CELLS - 1)) || (inf_x && inf_y)
               || out_x || out_y;
      prod    = {{DIVS_W{1'b0}}, cy_ff} * {{CELL_W{1'b0}}, divs};
      idx_sum = prod + (CELL_W + DIVS_W)'(cx_ff);

      cx_in = cx_ff;
      cy_in = cy_ff;
      tx_in = tx_ff;
      ty_in = ty_ff;
      n_in  = n_ff;
      if (cmd.walk_init) begin
         cx_in = cell_ff[AXIS_X];
         cy_in = cell_ff[AXIS_Y];
         tx_in = T_W'(tmax_ff[AXIS_X]);
         ty_in = T_W'(tmax_ff[AXIS_Y]);
         n_in  = '0;
      end else if (cmd.emit) begin
         if (stx) begin
            cx_in = nx;
            tx_in = tx_ff + T_W'(tdel_ff[AXIS_X]);
         end
         if (sty) begin
            cy_in = ny;
            ty_in = ty_ff + T_W'(tdel_ff[AXIS_Y]);
         end
         n_in = n_ff + 1'b1;
      end

      vld_in = vld_ff;
      if (cmd.emit) begin
         vld_in = 1'b1;
      end else if (out_ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      tx_ff <= tx_in;
      ty_ff <= ty_in;
      n_ff  <= n_in;
      if (cmd.emit) begin
         idx_ff  <= idx_sum[IDX_W-1:0];
         col_ff  <= cx_ff;
         row_ff  <= cy_ff;
         last_ff <= last;
         over_ff <= last && !at_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign status.div_done  = div_done;
   assign status.walk_last = last;
   assign status.out_free  = !vld_ff || out_ready;

   assign out_valid  = vld_ff;
   assign cell_index = idx_ff;
   assign cell_col   = col_ff;
   assign cell_row   = row_ff;
   assign last_cell  = last_ff;
   assign overrun    = over_ff;

endmodule

// ===== rtl/gscw_ctrl.sv =====
`timescale 1ns / 1ps
module gscw_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  gscw_pkg::status_type status,
   output gscw_pkg::cmd_type    cmd
);
   import gscw_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_DIV_GO   = 4'b0010,
      ST_DIV_WAIT = 4'b0100,
      ST_WALK     = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic      axis_ff, axis_in;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      axis_in       = axis_ff;
      in_ready      = 1'b0;
      cmd.load      = 1'b0;
      cmd.div_start = 1'b0;
      cmd.store     = 1'b0;
      cmd.walk_init = 1'b0;
      cmd.emit      = 1'b0;
      cmd.op        = op_ff;
      cmd.axis      = axis_ff;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               op_in    = OP_QSTART;
               axis_in  = AXIS_X;
               state_in = ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.store = 1'b1;
               if (op_ff == OP_TDEL) begin
                  if (axis_ff == AXIS_Y) begin
                     cmd.walk_init = 1'b1;
                     state_in      = ST_WALK;
                  end else begin
                     axis_in  = AXIS_Y;
                     op_in    = OP_QSTART;
                     state_in = ST_DIV_GO;
                  end
               end else begin
                  op_in    = op_type'(op_ff + 3'd1);
                  state_in = ST_DIV_GO;
               end
            end
         end
         ST_WALK: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.walk_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_QSTART;
         axis_ff  <= AXIS_X;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         axis_ff  <= axis_in;
      end
   end

endmodule

// ===== rtl/grid_segment_cell_walker.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Beat contents
// req_      in         tdata: start_x, start_y, end_x, end_y (23 bits each)
// rsp_      out        tdata: cell_index, cell_col, cell_row; tlast: last_cell;
//                      tuser: overrun
// csr_      in/out     APB registers cell_width_x, cell_width_y, divisions
//
// Each segment first runs twelve divisions on one shared restoring divider
// (one quotient bit per cycle, each division issued, then stored), then the
// walk emits one cell per cycle while the output is not stalled, up to 63 cells.
// Reset is synchronous and active high; it restores the register defaults.
// A stalled result beat holds in the output register and pauses the walk; the
// next segment is accepted as soon as the final cell is loaded there.
module grid_segment_cell_walker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [22:0] start_x, [45:23] start_y, [68:46] end_x, [91:69] end_y, rest zero
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [9:0] cell_index, [14:10] cell_col, [19:15] cell_row, rest zero
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast,
   // [0] overrun
   output logic [0:0]  rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import gscw_pkg::*;

   logic [COORD_W-1:0] cwx_ff, cwy_ff, width_x, width_y;
   logic [DIVS_W-1:0]  divs_ff, divs_used;
   logic               csr_wr;
   cmd_type            cmd;
   status_type         status;
   logic [IDX_W-1:0]   cell_index;
   logic [CELL_W-1:0]  cell_col, cell_row;
   logic               overrun;

   // Register file. Writes land on the access phase; reads are combinational.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cwx_ff  <= COORD_W'(256);
         cwy_ff  <= COORD_W'(256);
         divs_ff <= DIVS_W'(GRID_DIVS);
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_CWX:  cwx_ff  <= csr_pwdata[COORD_W-1:0];
            REG_CWY:  cwy_ff  <= csr_pwdata[COORD_W-1:0];
            REG_DIVS: divs_ff <= csr_pwdata[DIVS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_CWX:  csr_prdata = 32'(cwx_ff);
         REG_CWY:  csr_prdata = 32'(cwy_ff);
         REG_DIVS: csr_prdata = 32'(divs_ff);
         default:  csr_prdata = '0;
      endcase
   end

   // A zero width acts as one; divisions clamp into 1..GRID_DIVS.
   assign width_x = (cwx_ff == '0) ? COORD_W'(1) : cwx_ff;
   assign width_y = (cwy_ff == '0) ? COORD_W'(1) : cwy_ff;
   always_comb begin
      if (divs_ff == '0) begin
         divs_used = DIVS_W'(1);
      end else if (divs_ff > DIVS_W'(GRID_DIVS)) begin
         divs_used = DIVS_W'(GRID_DIVS);
      end else begin
         divs_used = divs_ff;
      end
   end

   gscw_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .status   (status),
      .cmd      (cmd)
   );

   gscw_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .start_x    (req_tdata[22:0]),
      .start_y    (req_tdata[45:23]),
      .end_x      (req_tdata[68:46]),
      .end_y      (req_tdata[91:69]),
      .width_x    (width_x),
      .width_y    (width_y),
      .divs       (divs_used),
      .out_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .cell_index (cell_index),
      .cell_col   (cell_col),
      .cell_row   (cell_row),
      .last_cell  (rsp_tlast),
      .overrun    (overrun)
   );

   assign rsp_tdata = {4'b0000, cell_row, cell_col, cell_index};
   assign rsp_tuser = overrun;

`ifndef SYNTHESIS
   // Overrun is only ever flagged on the closing cell of a walk.
   a_overrun_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> rsp_tlast)
      else $error("overrun flagged on a cell that is not the last");

   // Once a segment is taken, setup keeps the input closed.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input reopened right after a segment was accepted");

   // Every emitted cell lies inside the grid in use.
   a_cell_in_grid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (({1'b0, cell_col} < divs_used) && ({1'b0, cell_row} < divs_used)))
      else $error("emitted cell lies outside the grid");
`endif

endmodule

// ===== verif/tb_grid_segment_cell_walker.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the grid segment cell walker. Segments go in on the
// request stream, and every cell beat that comes back is checked against a
// DDA cell walk computed here from the segment and the current register
// settings. The registers are changed only while the block is idle.
module tb_grid_segment_cell_walker;
   import gscw_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0]  index;
      logic [CELL_W-1:0] col;
      logic [CELL_W-1:0] row;
      logic              last;
      logic              overrun;
   } cell_beat_type;

   localparam logic [63:0] T_NEVER = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam int IDLE_PCT = 28;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // The bench's own copy of the register file.
   logic [COORD_W-1:0] width_x;
   logic [COORD_W-1:0] width_y;
   logic [DIVS_W-1:0]  divs_reg;

   cell_beat_type pending_cells[$];
   int  mismatches;
   bit  no_idle;

   grid_segment_cell_walker u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Every input starts at a known value. Reset starts asserted and is released once.
   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
   end

   // Receiver back-pressure. It is drawn fresh each cycle unless a phase
   // asks for an uninterrupted stretch.
   always @(posedge clock) begin
      if (no_idle) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Sets up one axis of the walk: the start and end cells, the direction of
   // travel, the parameter of the first edge crossing and the spacing of
   // later crossings, the last two in Q48.16.
   task automatic setup_axis(input int unsigned a1, input int unsigned a2,
                             input int unsigned w_raw, input int unsigned d,
                             output int start_cell, output int endc, output int dir,
                             output logic [63:0] t_next, output logic [63:0] t_step);
      int unsigned w;
      int unsigned mag;
      int unsigned edge_gap;
      w = (w_raw == 0) ? 1 : w_raw;
      start_cell = (a1 / w) % d;
      endc = (a2 / w) % d;
      if (a2 > a1) begin
         mag = a2 - a1; dir = 1; edge_gap = w - (a1 % w);
      end else if (a2 < a1) begin
         mag = a1 - a2; dir = -1; edge_gap = a1 % w;
      end else begin
         dir = 0; t_next = T_NEVER; t_step = T_NEVER;
         return;
      end
      t_next = (64'(edge_gap) << 16) / 64'(mag);
      t_step = (64'(w) << 16) / 64'(mag);
   endtask

   function automatic cell_beat_type make_beat(int col, int row, int unsigned d);
      cell_beat_type b;
      b.index   = IDX_W'(col + row * d);
      b.col     = CELL_W'(col);
      b.row     = CELL_W'(row);
      b.last    = 1'b0;
      b.overrun = 1'b0;
      return b;
   endfunction

   // Appends the cells that one segment crosses, in walk order.
   task automatic walk_segment(input int unsigned x1, input int unsigned y1,
                               input int unsigned x2, input int unsigned y2);
      int unsigned d;
      int cx, cy, ex, ey, sx, sy, nx, ny, n;
      logic [63:0] tx, ty, dx, dy;
      bit stopped;
      cell_beat_type walk[$];
      d = (divs_reg < 1) ? 1 : ((divs_reg > GRID_DIVS) ? GRID_DIVS : divs_reg);
      setup_axis(x1, x2, width_x, d, cx, ex, sx, tx, dx);
      setup_axis(y1, y2, width_y, d, cy, ey, sy, ty, dy);
      stopped = 0;
      walk.push_back(make_beat(cx, cy, d));
      n = 1;
      while (cx != ex || cy != ey) begin
         nx = cx;
         ny = cy;
         if (n >= MAX_CELLS || (tx == T_NEVER && ty == T_NEVER)) begin
            stopped = 1;
            break;
         end
         // The axis whose next edge comes first steps; a tie steps both.
         if (tx < ty) begin
            nx += sx; tx += dx;
         end else if (tx == ty) begin
            nx += sx; tx += dx;
            ny += sy; ty += dy;
         end else begin
            ny += sy; ty += dy;
         end
         if (nx < 0 || ny < 0 || nx >= int'(d) || ny >= int'(d)) begin
            stopped = 1;
            break;
         end
         cx = nx;
         cy = ny;
         walk.push_back(make_beat(cx, cy, d));
         n++;
      end
      walk[walk.size()-1].last    = 1'b1;
      walk[walk.size()-1].overrun = stopped;
      foreach (walk[i]) pending_cells.push_back(walk[i]);
   endtask

   // Result checker: each accepted beat is compared with the oldest cell.
   always @(posedge clock) begin
      cell_beat_type got;
      cell_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.index   = rsp_tdata[9:0];
         got.col     = rsp_tdata[14:10];
         got.row     = rsp_tdata[19:15];
         got.last    = rsp_tlast;
         got.overrun = rsp_tuser[0];
         if (pending_cells.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected cell beat: idx=%0d col=%0d row=%0d last=%0b ovr=%0b",
                        got.index, got.col, got.row, got.last, got.overrun);
         end else begin
            want = pending_cells.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Cell mismatch: expected idx=%0d col=%0d row=%0d last=%0b ovr=%0b",
                           want.index, want.col, want.row, want.last, want.overrun);
                  $display("               got idx=%0d col=%0d row=%0d last=%0b ovr=%0b",
                           got.index, got.col, got.row, got.last, got.overrun);
               end
            end
         end
      end
   end

   // Sends one segment. Called at a rising edge; an optional gap goes first,
   // and the segment is predicted at the edge where the beat is taken.
   task automatic send_segment(input int unsigned x1, input int unsigned y1,
                               input int unsigned x2, input int unsigned y2);
      if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, y2[22:0], x2[22:0], y1[22:0], x1[22:0]};
      do @(posedge clock); while (!req_tready);
      walk_segment(x1, y1, x2, y2);
   endtask

   // Lowers valid and waits until every predicted cell has come back.
   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_cells.size() != 0) @(posedge clock);
   endtask

   // One APB write: setup cycle, then access cycle. pready is always high.
   task automatic csr_write(input logic [1:0] reg_sel, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (reg_sel)
         REG_CWX:  width_x  = value[COORD_W-1:0];
         REG_CWY:  width_y  = value[COORD_W-1:0];
         REG_DIVS: divs_reg = value[DIVS_W-1:0];
         default: begin
         end
      endcase
   endtask

   task automatic set_grid(input int unsigned wx, input int unsigned wy,
                           input int unsigned dv);
      drain();
      csr_write(REG_CWX, wx);
      csr_write(REG_CWY, wy);
      csr_write(REG_DIVS, dv);
   endtask

   // A coordinate that usually lies inside the grid extent on one axis.
   function automatic int unsigned grid_coord(int unsigned w);
      longint unsigned span;
      span = longint'((w == 0) ? 1 : w) * ((divs_reg == 0) ? 1 :
             ((divs_reg > GRID_DIVS) ? GRID_DIVS : divs_reg));
      if (span > 64'h7F_FFFF) span = 64'h80_0000;
      return $urandom_range(0, int'(span - 1));
   endfunction

   task automatic random_segments(input int count);
      int unsigned x1, y1, x2, y2;
      repeat (count) begin
         if ($urandom_range(0, 99) < 75) begin
            x1 = grid_coord(width_x); y1 = grid_coord(width_y);
            x2 = grid_coord(width_x); y2 = grid_coord(width_y);
            // Now and then an axis with no motion.
            if ($urandom_range(0, 9) == 0) x2 = x1;
            if ($urandom_range(0, 9) == 0) y2 = y1;
         end else begin
            x1 = $urandom_range(0, 23'h7F_FFFF); y1 = $urandom_range(0, 23'h7F_FFFF);
            x2 = $urandom_range(0, 23'h7F_FFFF); y2 = $urandom_range(0, 23'h7F_FFFF);
         end
         send_segment(x1, y1, x2, y2);
      end
   endtask

   // Directed segments on the default 32 x 32 grid of 256-wide cells.
   task automatic test_directed_defaults;
      send_segment(0, 0, 0, 0);                        // a single point
      send_segment(23'h7F_FFFF, 23'h7F_FFFF, 23'h7F_FFFF, 23'h7F_FFFF);
      send_segment(100, 300, 5000, 300);               // horizontal, rightward
      send_segment(5000, 300, 100, 300);               // horizontal, leftward
      send_segment(700, 7000, 700, 20);                // vertical, downward
      send_segment(0, 0, 8191, 8191);                  // diagonal through corners
      send_segment(8191, 8191, 0, 0);                  // same, backward
      send_segment(256, 512, 1024, 300);               // starts on cell edges
      send_segment(128, 128, 8100, 8000);              // long staircase
      send_segment(31 * 256 + 10, 40, 33 * 256, 900);  // leaves on the right
      send_segment(30, 31 * 256 + 5, 60, 32 * 256 + 7);// leaves at the top
      send_segment(0, 0, 23'h7F_FFFF, 23'h7F_FFFF);    // extreme corners
      send_segment(23'h7F_FFFF, 0, 0, 23'h7F_FFFF);
      send_segment(23'h55_5555, 23'h2A_AAAA, 23'h2A_AAAA, 23'h55_5555);
   endtask

   // Register extremes, including the out-of-range values the block clamps.
   task automatic test_register_extremes;
      set_grid(0, 0, 0);                               // zero width and divisions
      send_segment(3, 4, 9, 2);
      send_segment(0, 0, 0, 0);
      set_grid(23'h7F_FFFF, 23'h7F_FFFF, 1);           // one huge cell
      send_segment(0, 0, 23'h7F_FFFF, 23'h7F_FFFF);
      send_segment(23'h7F_FFFF, 12, 5, 23'h7F_FFFF);
      set_grid(1, 1, 63);                              // divisions clamp to 32
      send_segment(0, 0, 31, 31);
      send_segment(0, 31, 31, 0);
      send_segment(0, 0, 30, 31);                      // longest in-grid walk
      set_grid(256, 256, 32);
      // A write to an unused register address must change nothing.
      csr_write(2'd3, 32'hFFFF_FFFF);
      send_segment(10, 10, 2000, 900);
   endtask

   // Random segments under a series of grid settings.
   task automatic test_random_grids;
      int phase;
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_grid(256, 256, 32);
            1: set_grid(1, 1, 32);
            2: set_grid($urandom_range(1, 4096), $urandom_range(1, 4096),
                        $urandom_range(1, 32));
            3: set_grid(23'h7F_FFFF, 1, 2);
            4: set_grid($urandom_range(1, 23'h7F_FFFF), $urandom_range(1, 300), 32);
            default: set_grid($urandom_range(1, 600), $urandom_range(1, 600),
                              $urandom_range(0, 63));
         endcase
         random_segments(28);
      end
   endtask

   // A stretch where neither side idles.
   task automatic test_no_idle;
      set_grid(200, 300, 24);
      no_idle = 1;
      random_segments(25);
      drain();
      no_idle = 0;
   endtask

   // The sender holds off after each segment until all its cells are back.
   task automatic test_drained_sends;
      int k;
      set_grid(256, 256, 32);
      for (k = 0; k < 10; k++) begin
         random_segments(1);
         drain();
      end
   endtask

   initial begin
      mismatches = 0;
      no_idle    = 0;
      width_x    = 256;
      width_y    = 256;
      divs_reg   = 32;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_defaults();
      test_register_extremes();
      test_random_grids();
      test_no_idle();
      test_drained_sends();

      drain();
      // Let any stray beat surface before the verdict.
      repeat (600) @(posedge clock);
      mismatches += pending_cells.size();
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/gscw_pkg.sv
rtl/gscw_div.sv
rtl/gscw_dp.sv
rtl/gscw_ctrl.sv
rtl/grid_segment_cell_walker.sv
verif/tb_grid_segment_cell_walker.sv
